@@ rtl/core/periodic_trigger_spill_marker_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic trigger spill marker - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TRIGGER_SPILL_MARKER_DEFINES_SVH
`define PERIODIC_TRIGGER_SPILL_MARKER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define PTSM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ptsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic trigger spill marker - package
// Field widths, register indexes and item kinds shared by the block.
// ----------------------------------------------------------------------------
package ptsm_pkg;

    localparam int CFG_DATA_W    = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int TIME_FIELD_W  = 48;
    localparam int EVENT_W       = 31;
    localparam int SPILL_W       = 16;
    localparam int ENTRY_FIELD_W = 40;
    localparam int COUNT_W       = 32;

    localparam logic [SPILL_W-1:0] SPILL_RESET = 16'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_PAIR  = 32'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSPILL_GAP     = 3'd0,
        CFG_MARKER_GAP       = 3'd1,
        CFG_MARKER_GAP_TOL   = 3'd2,
        CFG_MARKER_DIST      = 3'd3,
        CFG_MARKER_DIST_TOL  = 3'd4
    } t_cfg_index;

    typedef enum logic {
        KIND_TRIGGER = 1'b0,
        KIND_FLUSH   = 1'b1
    } t_kind;

endpackage

@@ rtl/core/ptsm_cfg.sv @@
// ----------------------------------------------------------------------------
// Periodic trigger spill marker - configuration registers
// Holds the window settings and the signed window bounds derived from them.
// ----------------------------------------------------------------------------
module ptsm_cfg #(
    parameter int TIME_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ptsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptsm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [TIME_BITS-1:0]                o_offspill,
    output logic signed [TIME_BITS+1:0]         o_gap_lo,
    output logic signed [TIME_BITS+1:0]         o_gap_hi,
    output logic signed [TIME_BITS+1:0]         o_dist_lo,
    output logic signed [TIME_BITS+1:0]         o_dist_hi
);

    localparam int TW = TIME_BITS;

    logic [63:0]               w_data64;
    logic [TW-1:0]             w_value;
    logic [TW-1:0]             r_offspill, n_offspill;
    logic [TW-1:0]             r_mg, n_mg, r_mgt, n_mgt;
    logic [TW-1:0]             r_md, n_md, r_mdt, n_mdt;
    logic signed [TW+1:0]      r_gap_lo, r_gap_hi, r_dist_lo, r_dist_hi;
    logic signed [TW+1:0]      n_gap_lo, n_gap_hi, n_dist_lo, n_dist_hi;

    assign w_data64 = 64'(i_cfg_data);
    assign w_value  = w_data64[TW-1:0];

    always_comb begin
        n_offspill = r_offspill;
        n_mg       = r_mg;
        n_mgt      = r_mgt;
        n_md       = r_md;
        n_mdt      = r_mdt;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                ptsm_pkg::CFG_OFFSPILL_GAP:    n_offspill = w_value;
                ptsm_pkg::CFG_MARKER_GAP:      n_mg       = w_value;
                ptsm_pkg::CFG_MARKER_GAP_TOL:  n_mgt      = w_value;
                ptsm_pkg::CFG_MARKER_DIST:     n_md       = w_value;
                ptsm_pkg::CFG_MARKER_DIST_TOL: n_mdt      = w_value;
                default: ;
            endcase
        end
        // bounds are exclusive: nominal minus and plus tolerance
        n_gap_lo  = $signed({2'b00, n_mg}) - $signed({2'b00, n_mgt});
        n_gap_hi  = $signed({2'b00, n_mg}) + $signed({2'b00, n_mgt});
        n_dist_lo = $signed({2'b00, n_md}) - $signed({2'b00, n_mdt});
        n_dist_hi = $signed({2'b00, n_md}) + $signed({2'b00, n_mdt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offspill <= '0;
            r_mg       <= '0;
            r_mgt      <= '0;
            r_md       <= '0;
            r_mdt      <= '0;
            r_gap_lo   <= '0;
            r_gap_hi   <= '0;
            r_dist_lo  <= '0;
            r_dist_hi  <= '0;
        end else begin
            r_offspill <= n_offspill;
            r_mg       <= n_mg;
            r_mgt      <= n_mgt;
            r_md       <= n_md;
            r_mdt      <= n_mdt;
            r_gap_lo   <= n_gap_lo;
            r_gap_hi   <= n_gap_hi;
            r_dist_lo  <= n_dist_lo;
            r_dist_hi  <= n_dist_hi;
        end
    end

    assign o_offspill = r_offspill;
    assign o_gap_lo   = r_gap_lo;
    assign o_gap_hi   = r_gap_hi;
    assign o_dist_lo  = r_dist_lo;
    assign o_dist_hi  = r_dist_hi;

endmodule

@@ rtl/core/periodic_trigger_spill_marker.sv @@
// ----------------------------------------------------------------------------
// Periodic trigger spill marker - top level
// Finds marker trigger pairs in a timestamp stream and summarizes each spill.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one request per trigger: kind,
//   event_time, event_number, spill_number. Kind FLUSH ends the data and
//   reports the open spill. Output channel (o_valid/i_ready) carries one
//   spill summary when the spill number changes or on a flush request.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the five window
//   registers; it is always ready. It must be written only while the block
//   idles; the block itself does not enforce this. A summary passes the
//   input register, gap stage and threshold stage, then the state stage
//   that loads the result register.
//   Throughput: one request per cycle while o_ready is high. The gap stage
//   holds the previous trigger time; the state stage holds the last marker
//   and compares it against bounds prepared one stage earlier.
//   Stall: each stage moves on its own, so requests keep flowing while a
//   summary waits; only a request that would emit a second summary holds in
//   the state stage, and the stages behind it fill before o_ready drops.
//   Reset: synchronous, clears the valid flags, the stream count and the spill
//   state (current spill returns to 1); there is no memory and no clear pass.
// ----------------------------------------------------------------------------
`include "periodic_trigger_spill_marker_defines.svh"

module periodic_trigger_spill_marker #(
    parameter int TIME_BITS  = 48,
    parameter int ENTRY_BITS = 40
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // trigger requests
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic [ptsm_pkg::TIME_FIELD_W-1:0]    i_event_time,
    input  logic [ptsm_pkg::EVENT_W-1:0]         i_event_number,
    input  logic [ptsm_pkg::SPILL_W-1:0]         i_spill_number,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ptsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ptsm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // spill summaries
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ptsm_pkg::SPILL_W-1:0]         o_closed_spill,
    output logic                                 o_has_markers,
    output logic [ptsm_pkg::TIME_FIELD_W-1:0]    o_first_marker_time,
    output logic [ptsm_pkg::TIME_FIELD_W-1:0]    o_last_marker_time,
    output logic [ptsm_pkg::EVENT_W-1:0]         o_first_marker_event,
    output logic [ptsm_pkg::EVENT_W-1:0]         o_last_marker_event,
    output logic [ptsm_pkg::ENTRY_FIELD_W-1:0]   o_first_marker_entry,
    output logic [ptsm_pkg::ENTRY_FIELD_W-1:0]   o_last_marker_entry,
    output logic [ptsm_pkg::COUNT_W-1:0]         o_marker_count
);

    localparam int TW = TIME_BITS;
    localparam int EW = ENTRY_BITS;
    localparam int SW = TIME_BITS + 3;   // signed threshold width
    localparam int VW = ptsm_pkg::EVENT_W;
    localparam int PW = ptsm_pkg::SPILL_W;
    localparam int CW = ptsm_pkg::COUNT_W;

    // ---------------- configuration ----------------
    logic [TW-1:0]           w_offspill;
    logic signed [TW+1:0]    w_gap_lo, w_gap_hi, w_dist_lo, w_dist_hi;

    ptsm_cfg #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_offspill  (w_offspill),
        .o_gap_lo    (w_gap_lo),
        .o_gap_hi    (w_gap_hi),
        .o_dist_lo   (w_dist_lo),
        .o_dist_hi   (w_dist_hi)
    );

    assign o_cfg_ready = 1'b1;

    // ---------------- stage registers ----------------
    logic                    r_a_vld, r_b_vld, r_c_vld, r_res_vld;
    ptsm_pkg::t_kind         r_a_kind, r_b_kind, r_c_kind;
    logic [TW-1:0]           r_a_time;
    logic [VW-1:0]           r_a_event, r_b_event, r_c_event;
    logic [PW-1:0]           r_a_spill, r_b_spill, r_c_spill;
    logic [EW-1:0]           r_b_pos, r_c_pos;
    logic                    r_b_first2, r_c_first2;
    logic                    r_b_pair, r_c_pair;
    logic [TW-1:0]           r_b_mid, r_c_mid;
    logic signed [SW-1:0]    r_c_thr_hi, r_c_thr_lo;

    // stream tracking, owned by the gap stage
    logic [TW-1:0]           r_prev_time, n_prev_time;
    logic [EW-1:0]           r_items, n_items;

    // spill state, owned by the state stage
    logic [PW-1:0]           r_cur_spill, n_cur_spill;
    logic [TW-1:0]           r_lm_time, n_lm_time;
    logic [VW-1:0]           r_lm_event, n_lm_event;
    logic [EW-1:0]           r_lm_entry, n_lm_entry;
    logic                    r_lm_valid, n_lm_valid;
    logic                    r_good_found, n_good_found;
    logic [TW-1:0]           r_first_time, n_first_time, r_final_time, n_final_time;
    logic [VW-1:0]           r_first_event, n_first_event, r_final_event, n_final_event;
    logic [EW-1:0]           r_first_entry, n_first_entry, r_final_entry, n_final_entry;
    logic [CW-1:0]           r_good_count, n_good_count;

    // result register
    logic [PW-1:0]                          r_res_spill;
    logic                                   r_res_has;
    logic [ptsm_pkg::TIME_FIELD_W-1:0]      r_res_first_time, r_res_last_time;
    logic [VW-1:0]                          r_res_first_event, r_res_last_event;
    logic [ptsm_pkg::ENTRY_FIELD_W-1:0]     r_res_first_entry, r_res_last_entry;
    logic [CW-1:0]                          r_res_count;

    // ---------------- flow control ----------------
    logic w_c_emit, w_res_free, w_c_go, w_c_free, w_b_go, w_b_free, w_a_go, w_a_free;
    logic w_in_acc;

    // A summary is due on flush, or on a spill change past the first two triggers.
    assign w_c_emit   = (r_c_kind == ptsm_pkg::KIND_FLUSH) ||
                        (!r_c_first2 && (r_c_spill != r_cur_spill));
    assign w_res_free = !r_res_vld || i_ready;
    assign w_c_go     = r_c_vld && (!w_c_emit || w_res_free);
    assign w_c_free   = !r_c_vld || w_c_go;
    assign w_b_go     = r_b_vld && w_c_free;
    assign w_b_free   = !r_b_vld || w_c_free;
    assign w_a_go     = r_a_vld && w_b_free;
    assign w_a_free   = !r_a_vld || w_b_free;
    assign o_ready    = w_a_free;
    assign w_in_acc   = i_valid && w_a_free;

    // ---------------- input register ----------------
    logic [63:0] w_in_time64;
    assign w_in_time64 = 64'(i_event_time);

    // ---------------- gap stage ----------------
    // Signed gap against the previous trigger; the window test is exact.
    logic signed [TW:0]      w_gap;
    logic signed [TW+1:0]    w_gap_x;
    logic                    w_offspill_hit, w_pair_ok, w_first2;
    logic [TW-1:0]           w_mid;

    assign w_gap          = $signed({1'b0, r_a_time}) - $signed({1'b0, r_prev_time});
    assign w_gap_x        = $signed({w_gap[TW], w_gap});
    assign w_offspill_hit = !w_gap[TW] && (w_gap[TW-1:0] > w_offspill);
    assign w_pair_ok      = !w_offspill_hit && (w_gap_x > w_gap_lo) && (w_gap_x < w_gap_hi);
    // floored midpoint without overflow
    assign w_mid          = (r_a_time >> 1) + (r_prev_time >> 1) +
                            TW'(r_a_time[0] & r_prev_time[0]);
    assign w_first2       = (r_items[EW-1:1] == '0);

    always_comb begin
        n_prev_time = r_prev_time;
        n_items     = r_items;
        if (w_a_go) begin
            if (r_a_kind == ptsm_pkg::KIND_FLUSH) begin
                n_prev_time = '0;
                n_items     = '0;
            end else begin
                n_prev_time = r_a_time;
                if (r_items != '1) begin
                    n_items = r_items + EW'(1);
                end
            end
        end
    end

    // ---------------- threshold stage ----------------
    // Turn the spacing window into bounds on the last marker time:
    // lo < mid - last < hi  <=>  mid - hi < last < mid - lo.
    logic signed [SW-1:0] w_thr_hi, w_thr_lo;

    assign w_thr_hi = $signed({3'b000, r_b_mid}) - $signed({w_dist_lo[TW+1], w_dist_lo});
    assign w_thr_lo = $signed({3'b000, r_b_mid}) - $signed({w_dist_hi[TW+1], w_dist_hi});

    // ---------------- state stage ----------------
    logic signed [SW-1:0] w_lm_x;
    logic                 w_dist_ok;

    assign w_lm_x    = $signed({3'b000, r_lm_time});
    assign w_dist_ok = r_lm_valid && (w_lm_x < r_c_thr_hi) && (w_lm_x > r_c_thr_lo);

    always_comb begin
        n_cur_spill   = r_cur_spill;
        n_lm_time     = r_lm_time;
        n_lm_event    = r_lm_event;
        n_lm_entry    = r_lm_entry;
        n_lm_valid    = r_lm_valid;
        n_good_found  = r_good_found;
        n_first_time  = r_first_time;
        n_first_event = r_first_event;
        n_first_entry = r_first_entry;
        n_final_time  = r_final_time;
        n_final_event = r_final_event;
        n_final_entry = r_final_entry;
        n_good_count  = r_good_count;
        if (w_c_go) begin
            if (r_c_kind == ptsm_pkg::KIND_FLUSH) begin
                // drop everything but the registers
                n_cur_spill   = ptsm_pkg::SPILL_RESET;
                n_lm_time     = '0;
                n_lm_event    = '0;
                n_lm_entry    = '0;
                n_lm_valid    = 1'b0;
                n_good_found  = 1'b0;
                n_first_time  = '0;
                n_first_event = '0;
                n_first_entry = '0;
                n_final_time  = '0;
                n_final_event = '0;
                n_final_entry = '0;
                n_good_count  = '0;
            end else if (r_c_first2) begin
                n_cur_spill = r_c_spill;
            end else begin
                if (r_c_spill != r_cur_spill) begin
                    // open a new spill; the last marker carries over
                    n_cur_spill   = r_c_spill;
                    n_good_found  = 1'b0;
                    n_first_time  = '0;
                    n_first_event = '0;
                    n_first_entry = '0;
                    n_final_time  = '0;
                    n_final_event = '0;
                    n_final_entry = '0;
                    n_good_count  = '0;
                end
                if (r_c_pair) begin
                    if (w_dist_ok) begin
                        if (!n_good_found) begin
                            // first good pair logs its predecessor as well
                            n_first_time  = r_lm_time;
                            n_first_event = r_lm_event;
                            n_first_entry = r_lm_entry;
                            n_good_count  = ptsm_pkg::COUNT_PAIR;
                        end else if (n_good_count != ptsm_pkg::COUNT_MAX) begin
                            n_good_count = n_good_count + CW'(1);
                        end
                        n_good_found  = 1'b1;
                        n_final_time  = r_c_mid;
                        n_final_event = r_c_event;
                        n_final_entry = r_c_pos;
                    end
                    n_lm_time  = r_c_mid;
                    n_lm_event = r_c_event;
                    n_lm_entry = r_c_pos;
                    n_lm_valid = 1'b1;
                end
            end
        end
    end

    // widen or trim internal widths to the field widths
    logic [63:0] w_ft64, w_lt64, w_fe64, w_le64;
    assign w_ft64 = 64'(r_first_time);
    assign w_lt64 = 64'(r_final_time);
    assign w_fe64 = 64'(r_first_entry);
    assign w_le64 = 64'(r_final_entry);

    // ---------------- control and state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_c_vld       <= 1'b0;
            r_res_vld     <= 1'b0;
            r_prev_time   <= '0;
            r_items       <= '0;
            r_cur_spill   <= ptsm_pkg::SPILL_RESET;
            r_lm_time     <= '0;
            r_lm_event    <= '0;
            r_lm_entry    <= '0;
            r_lm_valid    <= 1'b0;
            r_good_found  <= 1'b0;
            r_first_time  <= '0;
            r_first_event <= '0;
            r_first_entry <= '0;
            r_final_time  <= '0;
            r_final_event <= '0;
            r_final_entry <= '0;
            r_good_count  <= '0;
        end else begin
            if (w_in_acc) begin
                r_a_vld <= 1'b1;
            end else if (w_a_go) begin
                r_a_vld <= 1'b0;
            end
            if (w_a_go) begin
                r_b_vld <= 1'b1;
            end else if (w_b_go) begin
                r_b_vld <= 1'b0;
            end
            if (w_b_go) begin
                r_c_vld <= 1'b1;
            end else if (w_c_go) begin
                r_c_vld <= 1'b0;
            end
            if (w_c_go && w_c_emit) begin
                r_res_vld <= 1'b1;
            end else if (i_ready) begin
                r_res_vld <= 1'b0;
            end
            r_prev_time   <= n_prev_time;
            r_items       <= n_items;
            r_cur_spill   <= n_cur_spill;
            r_lm_time     <= n_lm_time;
            r_lm_event    <= n_lm_event;
            r_lm_entry    <= n_lm_entry;
            r_lm_valid    <= n_lm_valid;
            r_good_found  <= n_good_found;
            r_first_time  <= n_first_time;
            r_first_event <= n_first_event;
            r_first_entry <= n_first_entry;
            r_final_time  <= n_final_time;
            r_final_event <= n_final_event;
            r_final_entry <= n_final_entry;
            r_good_count  <= n_good_count;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_kind  <= ptsm_pkg::t_kind'(i_kind);
            r_a_time  <= w_in_time64[TW-1:0];
            r_a_event <= i_event_number;
            r_a_spill <= i_spill_number;
        end
        if (w_a_go) begin
            r_b_kind   <= r_a_kind;
            r_b_event  <= r_a_event;
            r_b_spill  <= r_a_spill;
            r_b_pos    <= r_items;
            r_b_first2 <= w_first2;
            r_b_pair   <= w_pair_ok;
            r_b_mid    <= w_mid;
        end
        if (w_b_go) begin
            r_c_kind   <= r_b_kind;
            r_c_event  <= r_b_event;
            r_c_spill  <= r_b_spill;
            r_c_pos    <= r_b_pos;
            r_c_first2 <= r_b_first2;
            r_c_pair   <= r_b_pair;
            r_c_mid    <= r_b_mid;
            r_c_thr_hi <= w_thr_hi;
            r_c_thr_lo <= w_thr_lo;
        end
        // summary comes from the spill state before this request touches it
        if (w_c_go && w_c_emit) begin
            r_res_spill       <= r_cur_spill;
            r_res_has         <= r_good_found;
            r_res_first_time  <= w_ft64[ptsm_pkg::TIME_FIELD_W-1:0];
            r_res_last_time   <= w_lt64[ptsm_pkg::TIME_FIELD_W-1:0];
            r_res_first_event <= r_first_event;
            r_res_last_event  <= r_final_event;
            r_res_first_entry <= w_fe64[ptsm_pkg::ENTRY_FIELD_W-1:0];
            r_res_last_entry  <= w_le64[ptsm_pkg::ENTRY_FIELD_W-1:0];
            r_res_count       <= r_good_count;
        end
    end

    assign o_valid              = r_res_vld;
    assign o_closed_spill       = r_res_spill;
    assign o_has_markers        = r_res_has;
    assign o_first_marker_time  = r_res_first_time;
    assign o_last_marker_time   = r_res_last_time;
    assign o_first_marker_event = r_res_first_event;
    assign o_last_marker_event  = r_res_last_event;
    assign o_first_marker_entry = r_res_first_entry;
    assign o_last_marker_entry  = r_res_last_entry;
    assign o_marker_count       = r_res_count;

    // ---------------- assertions ----------------
    `PTSM_ASSERT_ALWAYS(a_count_tracks_found, (r_good_count != '0) == r_good_found, "marker count disagrees with found flag")
    `PTSM_ASSERT_ALWAYS(a_found_needs_marker, !r_good_found || r_lm_valid, "good marker logged without a last marker")
    `PTSM_ASSERT_NEXT(a_flush_clears, w_c_go && (r_c_kind == ptsm_pkg::KIND_FLUSH), !r_lm_valid && !r_good_found && (r_cur_spill == ptsm_pkg::SPILL_RESET), "flush left spill state behind")

endmodule
